// ----- hdl/swept_circle_collision_test_unit_macros.svh -----
// Assertion macros for the swept circle collision test unit.
`ifndef SWEPT_CIRCLE_COLLISION_TEST_UNIT_MACROS_SVH
`define SWEPT_CIRCLE_COLLISION_TEST_UNIT_MACROS_SVH

// Plain property, clocked on clk_i, off during reset.
`define SCCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication: cond |-> prop.
`define SCCT_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

`endif

// ----- hdl/scct_pkg.sv -----
// Package: types, widths and codes of the swept circle collision test unit.
`default_nettype none
package scct_pkg;

  localparam int DIFF_W   = 33;   // position / velocity difference, signed
  localparam int PROD_W   = 66;   // 33x33 signed product
  localparam int DD_W     = 65;   // |d|^2, unsigned
  localparam int PD_W     = 66;   // p.d and p x d, signed
  localparam int X_W      = 130;  // discriminant when non-negative
  localparam int ROOT_W   = X_W / 2;
  localparam int TIME_BITS = 16;
  localparam int TIME_W   = TIME_BITS + 1;
  localparam int FRONT_ST = 7;
  localparam int LATENCY  = FRONT_ST + ROOT_W + TIME_BITS + 3;

  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_NEG_DISC  = 2'd1;
  localparam logic [1:0] ST_NO_MOTION = 2'd2;
  localparam logic [1:0] ST_OUTSIDE   = 2'd3;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic [30:0]        radius_a;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [30:0]        radius_b;
  } scct_in_t;

  typedef struct packed {
    logic              hit;
    logic [TIME_W-1:0] impact_time;
    logic [1:0]        status;
  } scct_out_t;

  // Control that travels with an item between sections.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
  } scct_ctl_t;

endpackage
`default_nettype wire

// ----- hdl/scct_front.sv -----
// Front section: differences, products, divisor and discriminant.
`default_nettype none
module scct_front import scct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  scct_in_t               item_i,
  output scct_ctl_t              ctl_o,
  output logic [DD_W-1:0]        dd_o,
  output logic signed [PD_W-1:0] pd_o,
  output logic [X_W-1:0]         disc_o
);

  logic [FRONT_ST-1:0] vld_q;

  // s1
  logic signed [DIFF_W-1:0] px_q, py_q, dx_q, dy_q;
  logic [31:0]              rsum_q;
  // s2
  logic signed [PROD_W-1:0] xx_q, yy_q, pxdx_q, pydy_q, pxdy_q, pydx_q;
  logic [63:0]              r2_q;
  // s3
  logic [DD_W-1:0]          dd3_q;
  logic signed [PD_W-1:0]   pd3_q, cr3_q;
  logic [63:0]              r23_q;
  // s4
  logic [DD_W-1:0]          dd4_q;
  logic signed [PD_W-1:0]   pd4_q;
  logic [DD_W-1:0]          cra_q;
  logic [63:0]              r24_q;
  // s5
  logic [64:0]              p_hh_q, p_lh_q, c_hl_q;
  logic [63:0]              p_hl_q, p_ll_q, c_ll_q;
  logic [65:0]              c_hh_q;
  logic                     ddz5_q;
  logic [DD_W-1:0]          dd5_q;
  logic signed [PD_W-1:0]   pd5_q;
  // s6
  logic [X_W-1:0]           p1_q, p2_q;
  logic                     ddz6_q;
  logic [DD_W-1:0]          dd6_q;
  logic signed [PD_W-1:0]   pd6_q;
  // s7
  logic [X_W-1:0]           disc_q;
  logic [1:0]               st_q;
  logic [DD_W-1:0]          dd7_q;
  logic signed [PD_W-1:0]   pd7_q;

  logic [65:0]  mid_d;
  logic [X_W:0] disc_d;

  assign mid_d  = {2'b00, p_hl_q} + {1'b0, p_lh_q};
  assign disc_d = {1'b0, p1_q} - {1'b0, p2_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[FRONT_ST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // s1: relative motion and radius sum
    px_q   <= {item_i.pos_a_x[31], item_i.pos_a_x} - {item_i.pos_b_x[31], item_i.pos_b_x};
    py_q   <= {item_i.pos_a_y[31], item_i.pos_a_y} - {item_i.pos_b_y[31], item_i.pos_b_y};
    dx_q   <= {item_i.vel_a_x[31], item_i.vel_a_x} - {item_i.vel_b_x[31], item_i.vel_b_x};
    dy_q   <= {item_i.vel_a_y[31], item_i.vel_a_y} - {item_i.vel_b_y[31], item_i.vel_b_y};
    rsum_q <= {1'b0, item_i.radius_a} + {1'b0, item_i.radius_b};
    // s2: products
    xx_q   <= dx_q * dx_q;
    yy_q   <= dy_q * dy_q;
    pxdx_q <= px_q * dx_q;
    pydy_q <= py_q * dy_q;
    pxdy_q <= px_q * dy_q;
    pydx_q <= py_q * dx_q;
    r2_q   <= rsum_q * rsum_q;
    // s3: divisor, dot and cross
    dd3_q  <= {1'b0, xx_q[63:0]} + {1'b0, yy_q[63:0]};
    pd3_q  <= pxdx_q + pydy_q;
    cr3_q  <= pxdy_q - pydx_q;
    r23_q  <= r2_q;
    // s4: magnitude of the cross product
    cra_q  <= cr3_q[PD_W-1] ? DD_W'(-cr3_q) : cr3_q[DD_W-1:0];
    dd4_q  <= dd3_q;
    pd4_q  <= pd3_q;
    r24_q  <= r23_q;
    // s5: partial products of R^2*dd and cr^2
    p_hh_q <= r24_q[63:32] * dd4_q[64:32];
    p_hl_q <= r24_q[63:32] * dd4_q[31:0];
    p_lh_q <= r24_q[31:0] * dd4_q[64:32];
    p_ll_q <= r24_q[31:0] * dd4_q[31:0];
    c_hh_q <= cra_q[64:32] * cra_q[64:32];
    c_hl_q <= cra_q[64:32] * cra_q[31:0];
    c_ll_q <= cra_q[31:0] * cra_q[31:0];
    ddz5_q <= (dd4_q == '0);
    dd5_q  <= dd4_q;
    pd5_q  <= pd4_q;
    // s6: full products
    p1_q   <= {1'b0, p_hh_q, p_ll_q} + {32'b0, mid_d, 32'b0};
    p2_q   <= {c_hh_q, c_ll_q} + {32'b0, c_hl_q, 33'b0};
    ddz6_q <= ddz5_q;
    dd6_q  <= dd5_q;
    pd6_q  <= pd5_q;
    // s7: discriminant and early status
    disc_q <= disc_d[X_W-1:0];
    if (ddz6_q) begin
      st_q <= ST_NO_MOTION;
    end else if (disc_d[X_W]) begin
      st_q <= ST_NEG_DISC;
    end else begin
      st_q <= ST_HIT;
    end
    dd7_q  <= dd6_q;
    pd7_q  <= pd6_q;
  end

  assign ctl_o.valid  = vld_q[FRONT_ST-1];
  assign ctl_o.status = st_q;
  assign dd_o         = dd7_q;
  assign pd_o         = pd7_q;
  assign disc_o       = disc_q;

endmodule
`default_nettype wire

// ----- hdl/scct_sqrt.sv -----
// Pipelined integer square root, two radicand bits per stage.
`default_nettype none
module scct_sqrt import scct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scct_ctl_t              ctl_i,
  input  logic [DD_W-1:0]        dd_i,
  input  logic signed [PD_W-1:0] pd_i,
  input  logic [X_W-1:0]         disc_i,
  output scct_ctl_t              ctl_o,
  output logic [DD_W-1:0]        dd_o,
  output logic signed [PD_W-1:0] pd_o,
  output logic [ROOT_W-1:0]      root_o
);

  localparam int REM_W = ROOT_W + 1;

  logic                   vld_q  [ROOT_W];
  logic [1:0]             st_q   [ROOT_W];
  logic [DD_W-1:0]        dd_q   [ROOT_W];
  logic signed [PD_W-1:0] pd_q   [ROOT_W];
  logic [X_W-1:0]         x_q    [ROOT_W];
  logic [REM_W-1:0]       rem_q  [ROOT_W];
  logic [ROOT_W-1:0]      root_q [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic                   vld_in;
    logic [1:0]             st_in;
    logic [DD_W-1:0]        dd_in;
    logic signed [PD_W-1:0] pd_in;
    logic [X_W-1:0]         x_in;
    logic [REM_W-1:0]       rem_in;
    logic [ROOT_W-1:0]      root_in;
    logic [REM_W+1:0]       rem_n, trial;
    logic                   ge;

    if (k == 0) begin : g_first
      assign vld_in  = ctl_i.valid;
      assign st_in   = ctl_i.status;
      assign dd_in   = dd_i;
      assign pd_in   = pd_i;
      assign x_in    = disc_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign st_in   = st_q[k-1];
      assign dd_in   = dd_q[k-1];
      assign pd_in   = pd_q[k-1];
      assign x_in    = x_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_n = {rem_in, x_in[X_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (rem_n >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k]   <= st_in;
      dd_q[k]   <= dd_in;
      pd_q[k]   <= pd_in;
      x_q[k]    <= {x_in[X_W-3:0], 2'b00};
      rem_q[k]  <= ge ? REM_W'(rem_n - trial) : rem_n[REM_W-1:0];
      root_q[k] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign ctl_o.valid  = vld_q[ROOT_W-1];
  assign ctl_o.status = st_q[ROOT_W-1];
  assign dd_o         = dd_q[ROOT_W-1];
  assign pd_o         = pd_q[ROOT_W-1];
  assign root_o       = root_q[ROOT_W-1];

endmodule
`default_nettype wire

// ----- hdl/scct_div.sv -----
// Window test and pipelined restoring divider for the impact time.
`default_nettype none
module scct_div import scct_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  scct_ctl_t              ctl_i,
  input  logic [DD_W-1:0]        dd_i,
  input  logic signed [PD_W-1:0] pd_i,
  input  logic [ROOT_W-1:0]      root_i,
  output logic                   valid_o,
  output scct_out_t              res_o
);

  // numerator stage
  logic                   vla_q;
  logic [1:0]             sta_q;
  logic [DD_W-1:0]        dda_q;
  logic signed [PD_W:0]   num_q;
  logic signed [PD_W:0]   num_d;
  logic                   outside, q_top;

  // divide stages, stage 0 takes the window test result
  logic              vld_q [TIME_BITS+1];
  logic [1:0]        st_q  [TIME_BITS+1];
  logic [DD_W-1:0]   dd_q  [TIME_BITS+1];
  logic [DD_W-1:0]   rem_q [TIME_BITS+1];
  logic [TIME_W-1:0] quo_q [TIME_BITS+1];

  logic              vo_q;
  scct_out_t         res_q;
  logic              hit_d;

  assign num_d   = -$signed({pd_i[PD_W-1], pd_i}) - $signed({2'b00, root_i});
  assign outside = num_q[PD_W] || (num_q[PD_W-1:0] > {1'b0, dda_q});
  assign q_top   = (num_q[PD_W-1:0] == {1'b0, dda_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vla_q    <= 1'b0;
      vld_q[0] <= 1'b0;
    end else begin
      vla_q    <= ctl_i.valid;
      vld_q[0] <= vla_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sta_q    <= ctl_i.status;
    dda_q    <= dd_i;
    num_q    <= num_d;
    st_q[0]  <= (sta_q == ST_HIT && outside) ? ST_OUTSIDE : sta_q;
    dd_q[0]  <= dda_q;
    rem_q[0] <= q_top ? '0 : num_q[DD_W-1:0];
    quo_q[0] <= TIME_W'(q_top);
  end

  for (genvar k = 1; k <= TIME_BITS; k++) begin : g_step
    logic [DD_W:0] t;
    logic          ge;

    assign t  = {rem_q[k-1], 1'b0};
    assign ge = (t >= {1'b0, dd_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[k]  <= st_q[k-1];
      dd_q[k]  <= dd_q[k-1];
      rem_q[k] <= ge ? DD_W'(t - {1'b0, dd_q[k-1]}) : t[DD_W-1:0];
      quo_q[k] <= {quo_q[k-1][TIME_W-2:0], ge};
    end
  end

  assign hit_d = (st_q[TIME_BITS] == ST_HIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vld_q[TIME_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.hit         <= hit_d;
    res_q.impact_time <= hit_d ? quo_q[TIME_BITS] : '0;
    res_q.status      <= st_q[TIME_BITS];
  end

  assign valid_o = vo_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// ----- hdl/swept_circle_collision_test_unit.sv -----
// Top level: swept circle against circle collision test, fully pipelined.
// Throughput: one item per cycle; busy is never raised.
// Stages: 7 front (products, split 130-bit squares), 65 square-root, 19 divide/out.
// Reset clears only the valid bits; items in flight at reset are dropped.
// Results cannot be held off by the receiver, so the pipeline never stalls.
`default_nettype none
module swept_circle_collision_test_unit import scct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  scct_in_t  item_i,
  output logic      res_strobe_o,
  output scct_out_t res_o
);

  `include "swept_circle_collision_test_unit_macros.svh"

  scct_ctl_t              f_ctl, s_ctl;
  logic [DD_W-1:0]        f_dd, s_dd;
  logic signed [PD_W-1:0] f_pd, s_pd;
  logic [X_W-1:0]         f_disc;
  logic [ROOT_W-1:0]      s_root;

  // Every cycle takes a new item.
  assign busy = 1'b0;

  // Divisor |d|^2, p.d and discriminant R^2|d|^2 - (p x d)^2.
  scct_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .item_i  (item_i),
    .ctl_o   (f_ctl),
    .dd_o    (f_dd),
    .pd_o    (f_pd),
    .disc_o  (f_disc)
  );

  // floor(sqrt(disc)), one root bit per stage.
  scct_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (f_ctl),
    .dd_i   (f_dd),
    .pd_i   (f_pd),
    .disc_i (f_disc),
    .ctl_o  (s_ctl),
    .dd_o   (s_dd),
    .pd_o   (s_pd),
    .root_o (s_root)
  );

  // Smaller root (-p.d - sqrt) / dd: window test, then Q1.16 quotient.
  scct_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (s_ctl),
    .dd_i    (s_dd),
    .pd_i    (s_pd),
    .root_i  (s_root),
    .valid_o (res_strobe_o),
    .res_o   (res_o)
  );

  `SCCT_ASSERT_IMP(a_fixed_latency, start && !busy, ##LATENCY res_strobe_o, "result missing")
  `SCCT_ASSERT_IMP(a_hit_status, res_strobe_o, res_o.hit == (res_o.status == ST_HIT), "hit/status")
  `SCCT_ASSERT_IMP(a_miss_time, res_strobe_o && !res_o.hit, res_o.impact_time == '0, "time on miss")
  `SCCT_ASSERT_IMP(a_time_range, res_strobe_o && res_o.impact_time[TIME_BITS], res_o.impact_time[TIME_BITS-1:0] == '0, "time above one")

endmodule
`default_nettype wire

// ----- tb/sv/scct_checker.sv -----
// Checker: scoreboard and result predictor for the swept circle collision test unit.
`timescale 1ns / 1ps
module scct_checker import scct_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  logic      busy,
  input  scct_in_t  item_i,
  input  logic      res_strobe_o,
  input  scct_out_t res_o,
  output int        fail_cnt_o,
  output int        pending_o
);

  scct_out_t collision_q[$];

  // Floor square root over 96 result bits.
  function automatic logic [191:0] floor_sqrt(logic [191:0] x);
    logic [191:0] r, c;
    r = '0;
    for (int b = 95; b >= 0; b--) begin
      c = r | (192'd1 << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  // Solve |p + d t| = R for the earliest touch in the window.
  function automatic scct_out_t predict_collision(scct_in_t it);
    logic signed [191:0] ax, ay, avx, avy, bx, by, bvx, bvy;
    logic signed [191:0] px, py, dx, dy, rs, dd, pd, cr, disc, num;
    logic [191:0] root, quo;
    scct_out_t o;
    ax = it.pos_a_x;  ay = it.pos_a_y;  avx = it.vel_a_x;  avy = it.vel_a_y;
    bx = it.pos_b_x;  by = it.pos_b_y;  bvx = it.vel_b_x;  bvy = it.vel_b_y;
    px = ax - bx;  py = ay - by;  dx = avx - bvx;  dy = avy - bvy;
    rs = {161'd0, it.radius_a} + {161'd0, it.radius_b};
    dd   = dx * dx + dy * dy;
    pd   = px * dx + py * dy;
    cr   = px * dy - py * dx;
    disc = rs * rs * dd - cr * cr;
    o = '0;
    if (dd == 0) begin
      o.status = ST_NO_MOTION;
    end else if (disc < 0) begin
      o.status = ST_NEG_DISC;
    end else begin
      root = floor_sqrt(disc);
      num  = -pd - $signed(root);
      if (num < 0 || num > dd) begin
        o.status = ST_OUTSIDE;
      end else begin
        quo = (192'(num) << TIME_BITS) / 192'(dd);
        o.impact_time = quo[TIME_W-1:0];
        o.hit = 1'b1;
        o.status = ST_HIT;
      end
    end
    return o;
  endfunction

  initial fail_cnt_o = 0;

  always @(posedge clk_i) begin
    scct_out_t exp_res;
    if (rst_ni) begin
      if (res_strobe_o) begin
        if (collision_q.size() == 0) begin
          $display("%0t: result with none expected, actual %p", $time, res_o);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          exp_res = collision_q.pop_front();
          if (res_o.hit !== exp_res.hit || res_o.impact_time !== exp_res.impact_time ||
              res_o.status !== exp_res.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_res, res_o);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      if (start && !busy) collision_q = {collision_q, predict_collision(item_i)};
    end
    pending_o = collision_q.size();
  end

endmodule

// ----- tb/sv/swept_circle_collision_test_unit_tb.sv -----
// Testbench top: stimulus and verdict for the swept circle collision test unit.
`timescale 1ns / 1ps
module swept_circle_collision_test_unit_tb import scct_pkg::*;;

  localparam int ONE = 1 << 16;  // 1.0 in Q16.16

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  scct_in_t  item_i = '0;
  logic      res_strobe_o;
  scct_out_t res_o;
  int        fail_cnt;
  int        pending;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  swept_circle_collision_test_unit u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_strobe_o, .res_o
  );

  scct_checker u_chk (
    .clk_i, .rst_ni, .start, .busy, .item_i, .res_strobe_o, .res_o,
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Build one pair; velocities are displacements over the window.
  function automatic scct_in_t pair(int pax, int pay, int vax, int vay, int ra,
                                    int pbx, int pby, int vbx, int vby, int rb);
    scct_in_t it;
    it.pos_a_x = pax; it.pos_a_y = pay; it.vel_a_x = vax; it.vel_a_y = vay;
    it.radius_a = ra[30:0];
    it.pos_b_x = pbx; it.pos_b_y = pby; it.vel_b_x = vbx; it.vel_b_y = vby;
    it.radius_b = rb[30:0];
    return it;
  endfunction

  // Fully random bits: every field bit toggles over the run.
  function automatic scct_in_t noise_pair();
    scct_in_t it;
    it.pos_a_x = $urandom; it.pos_a_y = $urandom;
    it.vel_a_x = $urandom; it.vel_a_y = $urandom; it.radius_a = 31'($urandom);
    it.pos_b_x = $urandom; it.pos_b_y = $urandom;
    it.vel_b_x = $urandom; it.vel_b_y = $urandom; it.radius_b = 31'($urandom);
    return it;
  endfunction

  // Near-miss geometry: B in the central quarter of the range, A close by and heading roughly at it,
  // so hits, grazes, overlaps and misses all turn up often.
  function automatic scct_in_t aimed_pair();
    int sc, bx, by, ox, oy, ra, rb, vx, vy;
    sc = $urandom_range(4, 22);
    bx = $urandom; by = $urandom;
    bx = bx >>> 2; by = by >>> 2;
    ox = $urandom_range(0, 1 << sc) - (1 << (sc - 1));
    oy = $urandom_range(0, 1 << sc) - (1 << (sc - 1));
    ra = $urandom_range(0, 1 << (sc - 2));
    rb = $urandom_range(0, 1 << (sc - 2));
    vx = -ox * int'($urandom_range(1, 3)) / 2 + $urandom_range(0, 1 << (sc - 2)) - (1 << (sc - 3));
    vy = -oy * int'($urandom_range(1, 3)) / 2 + $urandom_range(0, 1 << (sc - 2)) - (1 << (sc - 3));
    if ($urandom_range(0, 9) == 0) begin
      vx = 0; vy = 0;  // same motion for both circles
    end
    return pair(bx + ox, by + oy, vx + bx / 64, vy, ra, bx, by, bx / 64, 0, rb);
  endfunction

  // Send one item: idle gap first, then hold start until the unit takes it.
  task automatic send_item(scct_in_t it, int gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  = 1'b1;
    item_i = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int draw_gap();
    // long stretches run back to back
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
  endfunction

  initial begin
    scct_in_t dir[$];
    int gap;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: stationary, extremes, t = 0, t = 1, mid hit, miss, overlap, apart
    dir = {dir, pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
    dir = {dir, pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h80000000, 32'h7fffffff)};
    dir = {dir, pair(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                     32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                     32'h7fffffff, 32'h7fffffff)};
    dir = {dir, pair(32'h80000000, 0, 32'h7fffffff, 0, 32'h7fffffff,
                     32'h7fffffff, 0, 32'h80000000, 0, 32'h7fffffff)};
    dir = {dir, pair(-2 * ONE, 0, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(-10 * ONE, 0, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(-4 * ONE, 0, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(-4 * ONE, 3 * ONE, 4 * ONE, 0, ONE, 0, 0, -4 * ONE, 0, ONE)};
    dir = {dir, pair(-4 * ONE, 10 * ONE, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(0, 0, ONE, 0, ONE, ONE / 2, 0, 0, 0, ONE)};
    dir = {dir, pair(4 * ONE, 0, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(-40 * ONE, 0, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    dir = {dir, pair(0, -4 * ONE, 0, 8 * ONE, 0, 0, 0, 0, 0, 0)};
    dir = {dir, pair(5 * ONE, 5 * ONE, 3 * ONE, 3 * ONE, 0, 5 * ONE, 5 * ONE,
                     3 * ONE, 3 * ONE, 0)};
    dir = {dir, pair(-4 * ONE, 2 * ONE, 8 * ONE, 0, ONE, 0, 0, 0, 0, ONE)};
    foreach (dir[i]) send_item(dir[i], draw_gap());

    for (int n = 0; n < 1535; n++) begin
      if (n == 700) begin
        // let the pipeline drain completely once
        start = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      gap = draw_gap();
      if ($urandom_range(0, 4) == 0) send_item(noise_pair(), gap);
      else send_item(aimed_pair(), gap);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 20) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("swept_circle_collision_test_unit regression: pass");
    end else begin
      $display("swept_circle_collision_test_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("swept_circle_collision_test_unit regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/scct_pkg.sv
hdl/scct_front.sv
hdl/scct_sqrt.sv
hdl/scct_div.sv
hdl/swept_circle_collision_test_unit.sv
tb/sv/scct_checker.sv
tb/sv/swept_circle_collision_test_unit_tb.sv
